// ===== design/phdt_pkg.sv =====
package phdt_pkg;

   // table geometry
   localparam int SLOTS         = 64;
   localparam int POINTS        = 5;
   localparam int OWNER_BITS    = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int POINT_BITS    = 3;
   localparam int CMD_BITS      = 2;
   localparam int STATUS_BITS   = 3;
   localparam int COUNT_BITS    = 7;
   localparam int COUNT_MAX     = 127;

   localparam int SLOT_IDX_BITS = $clog2(SLOTS);
   localparam int CNT_BITS      = $clog2(SLOTS + 1);

   // request commands
   localparam logic [CMD_BITS-1:0] CMD_REGISTER   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_UNREGISTER = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FIRE       = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_COUNT      = 2'd3;

   // response status codes
   localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_DUP      = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_INVALID  = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_NONE     = 3'd5;

   typedef struct packed {
      logic [OWNER_BITS-1:0]           owner;
      logic [POINT_BITS-1:0]           point;
      logic signed [PRIORITY_BITS-1:0] prio;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic push;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic point_bad;
      logic scan_done;
      logic out_free;
      logic res_last;
   } stat_type;

endpackage

// ===== design/phdt_dpath.sv =====
module phdt_dpath import phdt_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  ctl_type                         ctl,
   output stat_type                        stat,
   input  logic [CMD_BITS-1:0]             req_command,
   input  logic [OWNER_BITS-1:0]           req_owner_id,
   input  logic [POINT_BITS-1:0]           req_hook_point,
   input  logic signed [PRIORITY_BITS-1:0] req_priority_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [STATUS_BITS-1:0]          rsp_status,
   output logic [OWNER_BITS-1:0]           rsp_owner_out,
   output logic [COUNT_BITS-1:0]           rsp_count_out,
   output logic                            rsp_last
);

   // latched request
   logic [CMD_BITS-1:0]             cmd_ff;
   logic [OWNER_BITS-1:0]           owner_ff;
   logic [POINT_BITS-1:0]           point_ff;
   logic signed [PRIORITY_BITS-1:0] prio_ff;
   logic                            bad_ff;

   // table storage
   entry_type          mem [SLOTS];
   entry_type          rd_data_ff;
   logic [SLOTS-1:0]   valid_ff;
   logic [SLOTS-1:0]   done_ff;

   // scan pipeline
   logic                     issuing_ff;
   logic [SLOT_IDX_BITS-1:0] idx_ff;
   logic                     rd_vld_ff;
   logic [SLOT_IDX_BITS-1:0] rd_idx_ff;

   // accumulators
   logic                            free_found_ff;
   logic [SLOT_IDX_BITS-1:0]        free_idx_ff;
   logic                            dup_ff;
   logic                            removed_ff;
   logic [CNT_BITS-1:0]             cnt_ff;
   logic                            best_found_ff;
   logic [SLOT_IDX_BITS-1:0]        best_idx_ff;
   logic signed [PRIORITY_BITS-1:0] best_prio_ff;
   logic [OWNER_BITS-1:0]           best_owner_ff;

   // output stage
   logic                   out_valid_ff;
   logic [STATUS_BITS-1:0] out_status_ff;
   logic [OWNER_BITS-1:0]  out_owner_ff;
   logic [COUNT_BITS-1:0]  out_count_ff;
   logic                   out_last_ff;

   logic                   cur_valid;
   logic                   pt_hit;
   logic                   own_hit;
   logic                   elig;
   logic                   better;
   logic                   free_hit;
   logic [STATUS_BITS-1:0] res_status;
   logic [OWNER_BITS-1:0]  res_owner;
   logic [COUNT_BITS-1:0]  res_count;
   logic                   res_last;
   logic                   wr_en;
   logic                   mark;
   logic                   last_slot;

   // per-slot evaluation on registered read data
   assign cur_valid = valid_ff[rd_idx_ff];
   assign pt_hit    = rd_vld_ff && cur_valid && (rd_data_ff.point == point_ff);
   assign own_hit   = pt_hit && (rd_data_ff.owner == owner_ff);
   assign elig      = pt_hit && !done_ff[rd_idx_ff];
   assign better    = elig && (!best_found_ff ||
                      ($signed(rd_data_ff.prio) > $signed(best_prio_ff)));
   assign free_hit  = rd_vld_ff && !cur_valid && !free_found_ff;
   assign last_slot = (idx_ff == SLOT_IDX_BITS'(SLOTS - 1));

   always_comb begin
      res_status = ST_OK;
      res_owner  = '0;
      res_count  = '0;
      res_last   = 1'b1;
      if (bad_ff) begin
         res_status = ST_INVALID;
      end else begin
         unique case (cmd_ff)
            CMD_REGISTER: begin
               if (dup_ff)              res_status = ST_DUP;
               else if (!free_found_ff) res_status = ST_FULL;
            end
            CMD_UNREGISTER: begin
               if (!removed_ff) res_status = ST_NOTFOUND;
            end
            CMD_COUNT: begin
               res_count = (32'(cnt_ff) > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                                      : COUNT_BITS'(cnt_ff);
            end
            CMD_FIRE: begin
               if (cnt_ff == '0) begin
                  res_status = ST_NONE;
               end else begin
                  res_owner = best_owner_ff;
                  res_last  = (cnt_ff == CNT_BITS'(1));
               end
            end
            default: res_status = ST_OK;
         endcase
      end
   end

   assign wr_en = ctl.push && !bad_ff && (cmd_ff == CMD_REGISTER) && (res_status == ST_OK);
   assign mark  = ctl.push && !bad_ff && (cmd_ff == CMD_FIRE) && !res_last;

   assign stat.point_bad = ({1'b0, req_hook_point} >= (POINT_BITS + 1)'(POINTS));
   assign stat.scan_done = rd_vld_ff && (rd_idx_ff == SLOT_IDX_BITS'(SLOTS - 1));
   assign stat.out_free  = !out_valid_ff || !rsp_stall;
   assign stat.res_last  = res_last;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         owner_ff <= req_owner_id;
         point_ff <= req_hook_point;
         prio_ff  <= req_priority_in;
         bad_ff   <= stat.point_bad;
      end
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[free_idx_ff] <= '{owner: owner_ff, point: point_ff, prio: prio_ff};
      end
      if (issuing_ff) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (own_hit && (cmd_ff == CMD_UNREGISTER)) valid_ff[rd_idx_ff] <= 1'b0;
         if (wr_en) valid_ff[free_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else if (ctl.load) begin
         done_ff <= '0;
      end else if (mark) begin
         done_ff[best_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         idx_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         rd_idx_ff  <= '0;
      end else begin
         rd_vld_ff <= issuing_ff;
         rd_idx_ff <= idx_ff;
         if (ctl.start) begin
            issuing_ff <= 1'b1;
            idx_ff     <= '0;
         end else if (issuing_ff) begin
            idx_ff <= idx_ff + 1'b1;
            if (last_slot) issuing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         free_found_ff <= 1'b0;
         dup_ff        <= 1'b0;
         removed_ff    <= 1'b0;
         cnt_ff        <= '0;
         best_found_ff <= 1'b0;
      end else begin
         if (free_hit) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= rd_idx_ff;
         end
         if (own_hit) begin
            dup_ff     <= 1'b1;
            removed_ff <= 1'b1;
         end
         if (elig) cnt_ff <= cnt_ff + 1'b1;
         if (better) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= rd_idx_ff;
            best_prio_ff  <= rd_data_ff.prio;
            best_owner_ff <= rd_data_ff.owner;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.push) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         out_status_ff <= res_status;
         out_owner_ff  <= res_owner;
         out_count_ff  <= res_count;
         out_last_ff   <= res_last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_owner_out = out_owner_ff;
   assign rsp_count_out = out_count_ff;
   assign rsp_last      = out_last_ff;

endmodule

// ===== design/phdt_ctrl.sv =====
module phdt_ctrl import phdt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output ctl_type  ctl
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      ctl.load  = 1'b0;
      ctl.start = 1'b0;
      ctl.push  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               if (stat.point_bad) begin
                  state_in = S_PUSH;
               end else begin
                  ctl.start = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_PUSH;
         end
         S_PUSH: begin
            if (stat.out_free) begin
               ctl.push = 1'b1;
               if (stat.res_last) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.start = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== design/priority_hook_dispatch_table_top.sv =====
// hook dispatch table with SLOTS handler entries (owner, hook point, signed priority).
// one request is taken at a time; every command other than an invalid hook point
// walks the whole entry memory, one slot per cycle through its single registered read
// port, and register, unregister and count respond once the walk is done; an invalid
// hook point skips the walk and goes straight to its response.
// fire makes one pass over the table per response, each response emitted in
// descending priority with the lower slot winning ties and the final one marked by
// rsp_last. the finished response sits in an output register, so a new request is
// taken while it waits. the table is empty after reset with no clearing pass.
module priority_hook_dispatch_table_top import phdt_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [CMD_BITS-1:0]             req_command,
   input  logic [OWNER_BITS-1:0]           req_owner_id,
   input  logic [POINT_BITS-1:0]           req_hook_point,
   input  logic signed [PRIORITY_BITS-1:0] req_priority_in,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [STATUS_BITS-1:0]          rsp_status,
   output logic [OWNER_BITS-1:0]           rsp_owner_out,
   output logic [COUNT_BITS-1:0]           rsp_count_out,
   output logic                            rsp_last
);

   // commands and status between sequencer and table datapath
   ctl_type  ctl;
   stat_type stat;

   // sequencer: idle, scan, push of one response
   phdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // table memory, scan accumulators and output register
   phdt_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_command     (req_command),
      .req_owner_id    (req_owner_id),
      .req_hook_point  (req_hook_point),
      .req_priority_in (req_priority_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_owner_out   (rsp_owner_out),
      .rsp_count_out   (rsp_count_out),
      .rsp_last        (rsp_last)
   );

   // a taken request makes the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while block stays free");

   // a response is only loaded when the output register can take it
   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten in output register");

   // only fire produces responses that are not final, and they are always ok
   a_not_last_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == ST_OK && rsp_count_out == '0))
      else $error("non-final response with bad status or count");

   // a count or an owner never travels with an error status
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_owner_out == '0 && rsp_count_out == '0))
      else $error("error response carries payload");

endmodule

// ===== test/phdt_response_checker.sv =====
`timescale 1ns / 100ps

module phdt_response_checker import phdt_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [CMD_BITS-1:0]             req_command,
   input  logic [OWNER_BITS-1:0]           req_owner_id,
   input  logic [POINT_BITS-1:0]           req_hook_point,
   input  logic signed [PRIORITY_BITS-1:0] req_priority_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [STATUS_BITS-1:0]          rsp_status,
   input  logic [OWNER_BITS-1:0]           rsp_owner_out,
   input  logic [COUNT_BITS-1:0]           rsp_count_out,
   input  logic                            rsp_last,
   output int                              fail_count,
   output int                              pending_count,
   output int                              rsp_checked,
   output int                              full_seen
);

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [OWNER_BITS-1:0]  owner;
      logic [COUNT_BITS-1:0]  count;
      logic                   last;
   } hook_rsp_type;

   hook_rsp_type pending_rsp_q [$];

   // shadow copy of the handler table
   logic                            shadow_valid [SLOTS];
   logic [OWNER_BITS-1:0]           shadow_owner [SLOTS];
   logic [POINT_BITS-1:0]           shadow_point [SLOTS];
   logic signed [PRIORITY_BITS-1:0] shadow_prio  [SLOTS];

   task automatic push_rsp(input logic [STATUS_BITS-1:0] status,
                           input logic [OWNER_BITS-1:0] owner,
                           input int count, input logic last);
      hook_rsp_type r;
      r.status = status;
      r.owner  = owner;
      r.count  = COUNT_BITS'((count > COUNT_MAX) ? COUNT_MAX : count);
      r.last   = last;
      pending_rsp_q.push_back(r);
   endtask

   task automatic dispatch_model(input logic [CMD_BITS-1:0] cmd,
                                 input logic [OWNER_BITS-1:0] owner,
                                 input logic [POINT_BITS-1:0] point,
                                 input logic signed [PRIORITY_BITS-1:0] prio);
      int i;
      int k;
      int open_slot;
      int hits;
      int best;
      logic dup;
      logic found;
      logic [SLOTS-1:0] fired;
      open_slot = -1;
      hits      = 0;
      dup       = 1'b0;
      found     = 1'b0;
      fired     = '0;
      if (point >= POINTS) begin
         push_rsp(ST_INVALID, '0, 0, 1'b1);
         return;
      end
      case (cmd)
         CMD_REGISTER: begin
            for (i = 0; i < SLOTS; i++) begin
               if (!shadow_valid[i]) begin
                  if (open_slot < 0) open_slot = i;
               end else if (shadow_owner[i] == owner && shadow_point[i] == point) begin
                  dup = 1'b1;
               end
            end
            if (dup) begin
               push_rsp(ST_DUP, '0, 0, 1'b1);
            end else if (open_slot < 0) begin
               push_rsp(ST_FULL, '0, 0, 1'b1);
               full_seen++;
            end else begin
               shadow_valid[open_slot] = 1'b1;
               shadow_owner[open_slot] = owner;
               shadow_point[open_slot] = point;
               shadow_prio[open_slot]  = prio;
               push_rsp(ST_OK, '0, 0, 1'b1);
            end
         end
         CMD_UNREGISTER: begin
            for (i = 0; i < SLOTS; i++) begin
               if (shadow_valid[i] && shadow_owner[i] == owner && shadow_point[i] == point) begin
                  shadow_valid[i] = 1'b0;
                  found = 1'b1;
               end
            end
            push_rsp(found ? ST_OK : ST_NOTFOUND, '0, 0, 1'b1);
         end
         CMD_COUNT: begin
            for (i = 0; i < SLOTS; i++)
               if (shadow_valid[i] && shadow_point[i] == point) hits++;
            push_rsp(ST_OK, '0, hits, 1'b1);
         end
         default: begin
            for (i = 0; i < SLOTS; i++)
               if (shadow_valid[i] && shadow_point[i] == point) hits++;
            if (hits == 0) push_rsp(ST_NONE, '0, 0, 1'b1);
            // highest priority first, lower slot wins a tie
            for (k = 0; k < hits; k++) begin
               best = -1;
               for (i = 0; i < SLOTS; i++) begin
                  if (shadow_valid[i] && shadow_point[i] == point && !fired[i] &&
                      (best < 0 || shadow_prio[i] > shadow_prio[best]))
                     best = i;
               end
               fired[best] = 1'b1;
               push_rsp(ST_OK, shadow_owner[best], 0, k == hits - 1);
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      hook_rsp_type exp_rsp;
      if (reset) begin
         pending_rsp_q.delete();
         foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
         fail_count  = 0;
         rsp_checked = 0;
         full_seen   = 0;
      end else begin
         // responses first: none can belong to a request taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp_q.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, status %0h owner %0h",
                        $time, rsp_status, rsp_owner_out);
               fail_count++;
            end else begin
               exp_rsp = pending_rsp_q.pop_front();
               check_field("status", exp_rsp.status, rsp_status);
               check_field("owner_out", exp_rsp.owner, rsp_owner_out);
               check_field("count_out", exp_rsp.count, rsp_count_out);
               check_field("last", exp_rsp.last, rsp_last);
               rsp_checked++;
            end
         end
         if (req_valid && !req_stall)
            dispatch_model(req_command, req_owner_id, req_hook_point, req_priority_in);
      end
      pending_count = pending_rsp_q.size();
   end

endmodule

// ===== test/priority_hook_dispatch_table_top_tb.sv =====
`timescale 1ns / 100ps

module priority_hook_dispatch_table_top_tb;
   import phdt_pkg::*;

   // far beyond any correct run, even one with fires over a full table
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 200;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} stall_mode_type;

   logic                            clock           = 1'b0;
   logic                            reset           = 1'b1;
   logic                            req_valid       = 1'b0;
   logic                            req_stall;
   logic [CMD_BITS-1:0]             req_command     = CMD_COUNT;
   logic [OWNER_BITS-1:0]           req_owner_id    = '0;
   logic [POINT_BITS-1:0]           req_hook_point  = '0;
   logic signed [PRIORITY_BITS-1:0] req_priority_in = '0;
   logic                            rsp_valid;
   logic                            rsp_stall       = 1'b0;
   logic [STATUS_BITS-1:0]          rsp_status;
   logic [OWNER_BITS-1:0]           rsp_owner_out;
   logic [COUNT_BITS-1:0]           rsp_count_out;
   logic                            rsp_last;

   int fail_count;
   int pending_count;
   int rsp_checked;
   int full_seen;

   int cycle_count  = 0;
   int burst_left   = 0;
   int invalid_sent = 0;
   int sent_by_cmd [4];

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   // small owner pool so duplicates and successful unregisters turn up often
   logic [OWNER_BITS-1:0] owner_pool [8];
   // pairs placed while filling the table, reused for unregister
   logic [OWNER_BITS-1:0] filled_owner [$];
   logic [POINT_BITS-1:0] filled_point [$];

   int                    n;
   int                    r;
   int                    idx;
   logic [CMD_BITS-1:0]   cmd_v;
   logic [OWNER_BITS-1:0] owner_v;
   logic [POINT_BITS-1:0] point_v;

   priority_hook_dispatch_table_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_owner_id    (req_owner_id),
      .req_hook_point  (req_hook_point),
      .req_priority_in (req_priority_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_owner_out   (rsp_owner_out),
      .rsp_count_out   (rsp_count_out),
      .rsp_last        (rsp_last)
   );

   phdt_response_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_owner_id    (req_owner_id),
      .req_hook_point  (req_hook_point),
      .req_priority_in (req_priority_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_owner_out   (rsp_owner_out),
      .rsp_count_out   (rsp_count_out),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .rsp_checked     (rsp_checked),
      .full_seen       (full_seen)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver back-pressure: a new stall behaviour is drawn whenever its run counter expires,
   // including quiet stretches with no stall at all
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= stall_left[2];
      endcase
   end

   // one request; called and returns at a falling edge. the sender works in
   // bursts, dropping valid for a random gap once a burst runs out
   task automatic send_request(input logic [CMD_BITS-1:0] cmd,
                               input logic [OWNER_BITS-1:0] owner,
                               input logic [POINT_BITS-1:0] point,
                               input logic signed [PRIORITY_BITS-1:0] prio);
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 6);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_owner_id    <= owner;
      req_hook_point  <= point;
      req_priority_in <= prio;
      if (point >= POINTS) invalid_sent++;
      else sent_by_cmd[cmd]++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   // hold off the sender until every predicted response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic logic [OWNER_BITS-1:0] pick_owner();
      case ($urandom_range(0, 9))
         0:             return '0;
         1:             return '1;
         2, 3, 4, 5, 6: return owner_pool[$urandom_range(0, 7)];
         default:       return OWNER_BITS'($urandom);
      endcase
   endfunction

   // mostly valid hook points, now and then one of the invalid ones
   function automatic logic [POINT_BITS-1:0] pick_point();
      if ($urandom_range(0, 9) == 0) return POINT_BITS'($urandom_range(POINTS, 7));
      return POINT_BITS'($urandom_range(0, POINTS - 1));
   endfunction

   // near-zero values make ties likely, extremes and full-range values cover the sign
   function automatic logic signed [PRIORITY_BITS-1:0] pick_prio();
      case ($urandom_range(0, 9))
         0:             return {1'b1, {(PRIORITY_BITS-1){1'b0}}};
         1:             return {1'b0, {(PRIORITY_BITS-1){1'b1}}};
         2, 3, 4, 5, 6: return PRIORITY_BITS'($signed($urandom_range(0, 4)) - 2);
         default:       return PRIORITY_BITS'($urandom);
      endcase
   endfunction

   initial begin
      foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
      foreach (owner_pool[i]) owner_pool[i] = OWNER_BITS'($urandom);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // empty table: fire gives none, count gives zero, unregister finds nothing
      send_request(CMD_FIRE,       16'h0000, 3'd0, 16'sd0);
      send_request(CMD_COUNT,      16'h0000, 3'd4, 16'sd0);
      send_request(CMD_UNREGISTER, 16'h1234, 3'd2, 16'sd0);
      // invalid hook point for every command
      send_request(CMD_REGISTER,   16'h1111, 3'd5, 16'sd7);
      send_request(CMD_UNREGISTER, 16'h1111, 3'd6, 16'sd0);
      send_request(CMD_FIRE,       16'hFFFF, 3'd7, 16'sd0);
      send_request(CMD_COUNT,      16'h0000, 3'd7, 16'sd0);
      // owner and priority extremes, plus a tie between slots 2 and 3
      send_request(CMD_REGISTER,   16'h0000, 3'd0, -16'sd32768);
      send_request(CMD_REGISTER,   16'hFFFF, 3'd0, 16'sd32767);
      send_request(CMD_REGISTER,   16'h1234, 3'd0, 16'sd0);
      send_request(CMD_REGISTER,   16'h0005, 3'd0, 16'sd0);
      // same pair again is a duplicate, same owner on another point is not
      send_request(CMD_REGISTER,   16'h0000, 3'd0, 16'sd5);
      send_request(CMD_REGISTER,   16'h0000, 3'd4, -16'sd1);
      send_request(CMD_COUNT,      16'h0000, 3'd0, 16'sd0);
      send_request(CMD_FIRE,       16'h0000, 3'd0, 16'sd0);
      // free slot 2 and refill it, so the new owner wins the tie on the lower slot
      send_request(CMD_UNREGISTER, 16'h1234, 3'd0, 16'sd0);
      send_request(CMD_REGISTER,   16'hAAAA, 3'd0, 16'sd0);
      send_request(CMD_FIRE,       16'h0000, 3'd0, 16'sd0);
      send_request(CMD_FIRE,       16'h0000, 3'd4, 16'sd0);
      send_request(CMD_UNREGISTER, 16'hFFFF, 3'd4, 16'sd0);
      send_request(CMD_UNREGISTER, 16'h0000, 3'd4, 16'sd0);
      send_request(CMD_COUNT,      16'h5555, 3'd4, 16'sd0);

      // ---- random mix over a small owner pool ----
      for (n = 0; n < 10; n++) begin
         r = $urandom_range(0, 99);
         if (r < 40)      cmd_v = CMD_REGISTER;
         else if (r < 65) cmd_v = CMD_UNREGISTER;
         else if (r < 82) cmd_v = CMD_FIRE;
         else             cmd_v = CMD_COUNT;
         send_request(cmd_v, pick_owner(), pick_point(), pick_prio());
      end

      // sender waits for the block to empty completely
      drain_responses();

      // ---- fill the table past capacity, crowding points 0 and 1 ----
      // the low bits of the owner keep every pair distinct
      for (n = 0; n < SLOTS + 4; n++) begin
         owner_v      = OWNER_BITS'($urandom);
         owner_v[6:0] = n[6:0];
         if ($urandom_range(0, 4) < 3) point_v = POINT_BITS'($urandom_range(0, 1));
         else                          point_v = POINT_BITS'($urandom_range(0, POINTS - 1));
         filled_owner.push_back(owner_v);
         filled_point.push_back(point_v);
         send_request(CMD_REGISTER, owner_v, point_v, pick_prio());
      end

      // full table: long fires and counts on every point, invalid ones too
      for (n = 0; n < 8; n++) begin
         send_request(CMD_FIRE,  pick_owner(), POINT_BITS'(n), pick_prio());
         send_request(CMD_COUNT, pick_owner(), POINT_BITS'(n), pick_prio());
      end

      // thin it out again, with some misses mixed in
      for (n = 0; n < 6; n++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_request(CMD_UNREGISTER, pick_owner(), pick_point(), pick_prio());
         end else begin
            idx = $urandom_range(0, filled_owner.size() - 1);
            send_request(CMD_UNREGISTER, filled_owner[idx], filled_point[idx], pick_prio());
         end
      end

      // refill freed slots, then fire each valid point once more
      for (n = 0; n < 3; n++)
         send_request(CMD_REGISTER, pick_owner(), pick_point(), pick_prio());
      for (n = 0; n < POINTS; n++)
         send_request(CMD_FIRE, pick_owner(), POINT_BITS'(n), pick_prio());

      drain_responses();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("sent %0d register, %0d unregister, %0d fire and %0d count requests",
               sent_by_cmd[CMD_REGISTER], sent_by_cmd[CMD_UNREGISTER],
               sent_by_cmd[CMD_FIRE], sent_by_cmd[CMD_COUNT]);
      $display("plus %0d on bad points; checked %0d responses, table refused as full %0d times",
               invalid_sent, rsp_checked, full_seen);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
design/phdt_pkg.sv
design/phdt_dpath.sv
design/phdt_ctrl.sv
design/priority_hook_dispatch_table_top.sv
test/phdt_response_checker.sv
test/priority_hook_dispatch_table_top_tb.sv
